// ===== rtl/core/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared sizes, codes and controller/datapath handshake types for the
// first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int NUM_BLOCKS = 1024;

   // field widths of the item channels
   localparam int FREE_IDX_W = 11;
   localparam int BIDX_W     = 10;
   localparam int STATUS_W   = 2;

   // used map is held as 64-bit words in a RAM
   localparam int WORD_W     = 64;
   localparam int BIT_W      = 6;
   localparam int WORD_COUNT = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int PIDX_W     = ADDR_W + BIT_W;

   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);

   // blocks that exist in the last word; bits above are never handed out
   localparam int TAIL_BITS = NUM_BLOCKS % WORD_W;
   localparam logic [WORD_W-1:0] TAIL_MASK =
      (TAIL_BITS == 0) ? {WORD_W{1'b1}} : ((WORD_W'(1) << TAIL_BITS) - WORD_W'(1));

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic clear_wr;
      logic latch;
      logic rd_next;
      logic commit_alloc;
      logic commit_full;
      logic commit_free;
      logic commit_invalid;
   } dp_cmd_type;

   typedef struct packed {
      logic req_is_free;
      logic free_ok;
      logic word_has_zero;
      logic scan_last;
      logic clear_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== rtl/core/bba_req_if.sv =====
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: valid/ready handshake carrying one allocate or free item.
// ----------------------------------------------------------------------------
interface bba_req_if
   import bba_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [FREE_IDX_W-1:0] free_index;

   modport source (output valid, output command, output free_index, input ready);
   modport sink   (input valid, input command, input free_index, output ready);
endinterface

// ===== rtl/core/bba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel: valid/ready handshake carrying one status item.
// ----------------------------------------------------------------------------
interface bba_rsp_if
   import bba_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [STATUS_W-1:0] status;
   logic [BIDX_W-1:0] block_index;

   modport source (output valid, output status, output block_index, input ready);
   modport sink   (input valid, input status, input block_index, output ready);
endinterface

// ===== rtl/core/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clears the map after reset, then runs each allocate scan or
// free update and hands the result to the output register.
// ----------------------------------------------------------------------------
module bba_ctrl
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_FREE
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = stat.req_is_free ? ST_FREE : ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            priority if (stat.word_has_zero) begin
               if (stat.out_free) begin
                  cmd.commit_alloc = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else if (stat.scan_last) begin
               if (stat.out_free) begin
                  cmd.commit_full = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         ST_FREE: begin
            if (stat.out_free) begin
               cmd.commit_free    = stat.free_ok;
               cmd.commit_invalid = !stat.free_ok;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
endmodule

// ===== rtl/core/bba_dpath.sv =====
// ----------------------------------------------------------------------------
// bba_dpath
// Datapath: used-map RAM, word counter, request latch, first-zero search
// and the response output register.
// ----------------------------------------------------------------------------
module bba_dpath
   import bba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_command,
   input  logic [FREE_IDX_W-1:0] req_free_index,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [BIDX_W-1:0]     rsp_block_index
);
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              cmd_ff;
   logic [PIDX_W-1:0] pidx_ff;
   logic              idx_ok_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff;
   logic [BIDX_W-1:0] bidx_ff;

   logic [PIDX_W-1:0] req_pidx;
   logic              req_idx_ok;
   logic [ADDR_W-1:0] free_word;
   logic [WORD_W-1:0] free_mask;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   logic [WORD_W-1:0] zeros;
   logic [WORD_W-1:0] lowest;
   logic [BIT_W-1:0]  bit_pos;
   logic [PIDX_W-1:0] alloc_pidx;

   // indexes wider than the map are caught by the range check first
   assign req_pidx   = PIDX_W'(req_free_index);
   assign req_idx_ok = 32'(req_free_index) < 32'(NUM_BLOCKS);
   assign free_word  = pidx_ff[PIDX_W-1:BIT_W];
   assign free_mask  = WORD_W'(1) << pidx_ff[BIT_W-1:0];

   // free bits of the scanned word, isolated lowest one
   assign zeros  = ~ram_rd_data & ((cnt_ff == LAST_WORD) ? TAIL_MASK : {WORD_W{1'b1}});
   assign lowest = zeros & (~zeros + WORD_W'(1));

   always_comb begin
      bit_pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (lowest[i]) begin
            bit_pos = bit_pos | BIT_W'(i);
         end
      end
   end

   assign alloc_pidx = {cnt_ff, bit_pos};

   always_comb begin
      ram_rd_en   = (cmd.latch && (req_command == CMD_ALLOC || req_idx_ok)) || cmd.rd_next;
      ram_rd_addr = cmd.latch ? ((req_command == CMD_FREE) ? req_pidx[PIDX_W-1:BIT_W] : '0)
                              : cnt_ff + ADDR_W'(1);
      ram_wr_en   = cmd.clear_wr || cmd.commit_alloc || cmd.commit_free;
      ram_wr_addr = cmd.commit_free ? free_word : cnt_ff;
      priority if (cmd.commit_alloc) begin
         ram_wr_data = ram_rd_data | lowest;
      end else if (cmd.commit_free) begin
         ram_wr_data = ram_rd_data & ~free_mask;
      end else begin
         ram_wr_data = '0;
      end
   end

   bba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_COUNT)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      priority if (cmd.latch) begin
         cnt_in = '0;
      end else if (cmd.clear_wr || cmd.rd_next) begin
         cnt_in = cnt_ff + ADDR_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit_alloc || cmd.commit_full || cmd.commit_free || cmd.commit_invalid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff    <= req_command;
         pidx_ff   <= req_pidx;
         idx_ok_ff <= req_idx_ok;
      end
      priority if (cmd.commit_alloc) begin
         status_ff <= STATUS_OK;
         bidx_ff   <= BIDX_W'(alloc_pidx);
      end else if (cmd.commit_full) begin
         status_ff <= STATUS_FULL;
         bidx_ff   <= '0;
      end else if (cmd.commit_free) begin
         status_ff <= STATUS_OK;
         bidx_ff   <= '0;
      end else if (cmd.commit_invalid) begin
         status_ff <= STATUS_INVALID;
         bidx_ff   <= '0;
      end else begin
         status_ff <= status_ff;
         bidx_ff   <= bidx_ff;
      end
   end

   always_comb begin
      stat.req_is_free   = (req_command == CMD_FREE);
      stat.free_ok       = idx_ok_ff && (cmd_ff == CMD_FREE);
      stat.word_has_zero = |zeros;
      stat.scan_last     = (cnt_ff == LAST_WORD);
      stat.clear_last    = (cnt_ff == LAST_WORD);
      stat.out_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_block_index = bidx_ff;
endmodule

// ===== rtl/core/bitmap_block_allocator_core.sv =====
// Allocate: the result waits on the scan of one 64-bit map word per cycle from the map RAM,
//   up to WORD_COUNT words (16 at 1024 blocks), and on a free output register.
// Free: one RAM read of the map word, then the write-back as the result is registered.
// One item at a time: the next item is taken the cycle after a result is registered.
// Reset: synchronous; the map RAM is then cleared one word per cycle (all WORD_COUNT words,
//   16 at 1024 blocks) with req_chan.ready low.
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a used-bit map, controller plus datapath.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core
   import bba_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan
);
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   logic        req_ready;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bba_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_chan.command),
      .req_free_index  (req_chan.free_index),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_block_index (rsp_chan.block_index)
   );

   assign req_chan.ready = req_ready;

   // a result is only committed into a free output register
   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.commit_alloc || dp_cmd.commit_full || dp_cmd.commit_free ||
       dp_cmd.commit_invalid) |-> dp_stat.out_free)
      else $error("result committed over a pending response");

   a_one_commit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.commit_alloc, dp_cmd.commit_full, dp_cmd.commit_free,
                dp_cmd.commit_invalid, dp_cmd.clear_wr, dp_cmd.latch}))
      else $error("conflicting datapath commands");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("item accepted while previous one in flight");

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_wr |-> !req_chan.ready)
      else $error("request taken during map clear");
endmodule
